@@ design/fcw_pkg.sv @@
// ----------------------------------------------------------------------------
// fcw_pkg
// Shared types and constants of the FAT12 cluster chain walker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fcw_pkg;

  // FAT store geometry
  localparam int TABLE_BYTES = 8192;
  localparam int ADDR_W      = $clog2(TABLE_BYTES);
  localparam int BANK_DEPTH  = TABLE_BYTES / 2;
  localparam int BANK_AW     = ADDR_W - 1;
  // wide enough for any byte index of a 12-bit cluster and for the store size
  localparam int IDX_W       = 17;

  // field widths
  localparam int CLUSTER_W = 12;
  localparam int LBA_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 16;
  localparam int DIVD_W    = 21;
  localparam int DIVS_W    = 13;

  // opcodes
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_STEP  = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_CHAIN = 2'd1;
  localparam logic [1:0] ST_BAD      = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_SECTOR    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SECTORS_PER_CLUSTER = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RESERVED_SECTORS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SECTORS_PER_FAT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FAT_COPIES          = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ROOT_ENTRIES        = 3'd5;

  // FAT12 constants
  localparam logic [CLUSTER_W-1:0] END_MARK           = 12'hFF8;
  localparam logic [CLUSTER_W-1:0] FIRST_DATA_CLUSTER = 12'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_STEP
  } state_t;

endpackage

`default_nettype wire

@@ design/fat12_cluster_chain_walker_top.sv @@
// ----------------------------------------------------------------------------
// fat12_cluster_chain_walker_top
// Walks a FAT12 cluster chain over a locally held FAT table.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): opcode 0 writes table_byte at
//   table_address, opcode 1 starts a chain at start_cluster, opcode 2 steps
//   the chain. Only a step returns a word on the output channel
//   (out_valid / out_stall) with cluster, sector_lba, sector_count,
//   next_cluster, end_of_chain and status.
//   In a step the FAT entry is read from the two-bank FAT memory when the
//   step is accepted, and the result word is loaded in state S_STEP. A start
//   waits in state S_DIV for the one-bit-a-cycle root directory size
//   division. Items are handled one at a time; in_stall is high while an
//   item is in progress.
//   The result register holds a word until taken; a step waits in S_STEP
//   while out_stall keeps the previous word in place. A write or start
//   is still accepted while a result waits.
//   The user writes configuration (cfg_write / cfg_index / cfg_data) only
//   while idle; the block does not enforce it. Reset (synchronous) restores
//   the register defaults and clears the chain; the FAT memory is not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fat12_cluster_chain_walker_top import fcw_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // configuration
  input  wire logic                 cfg_write,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  // input channel
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [1:0]           opcode,
  input  wire logic [12:0]          table_address,
  input  wire logic [7:0]           table_byte,
  input  wire logic [CLUSTER_W-1:0] start_cluster,
  // output channel
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic      [CLUSTER_W-1:0] cluster,
  output logic      [LBA_W-1:0]     sector_lba,
  output logic      [7:0]           sector_count,
  output logic      [CLUSTER_W-1:0] next_cluster,
  output logic                      end_of_chain,
  output logic      [1:0]           status
);

  // configuration registers
  logic [12:0] bytes_per_sector;
  logic [7:0]  sectors_per_cluster;
  logic [15:0] reserved_sectors;
  logic [15:0] sectors_per_fat;
  logic [7:0]  fat_copies;
  logic [15:0] root_entries;

  // chain state
  logic [CLUSTER_W-1:0] current_cluster;
  logic                 chain_active;
  logic [LBA_W-1:0]     data_start_lba;

  state_t state;
  state_t state_next;

  logic                 accept;
  logic                 do_write;
  logic                 do_start;
  logic                 do_step;
  logic                 out_free;
  logic                 finish_step;
  logic [23:0]          fat_area;
  logic [15:0]          reserved_hold;
  logic [19:0]          cluster_ofs;
  logic [CLUSTER_W-1:0] entry;
  logic                 div_done;
  logic [DIVD_W-1:0]    root_secs;
  logic                 is_end;

  assign accept      = in_valid && !in_stall;
  assign do_write    = accept && (opcode == OP_WRITE);
  assign do_start    = accept && (opcode == OP_START);
  assign do_step     = accept && (opcode == OP_STEP);
  assign out_free    = !out_valid || !out_stall;
  assign finish_step = (state == S_STEP) && out_free;
  assign is_end      = entry >= END_MARK;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_per_sector    <= 13'd512;
      sectors_per_cluster <= 8'd1;
      reserved_sectors    <= 16'd1;
      sectors_per_fat     <= 16'd9;
      fat_copies          <= 8'd2;
      root_entries        <= 16'd224;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_BYTES_PER_SECTOR:    bytes_per_sector    <= cfg_data[12:0];
        REG_SECTORS_PER_CLUSTER: sectors_per_cluster <= cfg_data[7:0];
        REG_RESERVED_SECTORS:    reserved_sectors    <= cfg_data;
        REG_SECTORS_PER_FAT:     sectors_per_fat     <= cfg_data;
        REG_FAT_COPIES:          fat_copies          <= cfg_data[7:0];
        REG_ROOT_ENTRIES:        root_entries        <= cfg_data;
        default: ;
      endcase
    end
  end

  // FAT store
  fcw_fat u_fat (
    .clk       (clk),
    .wr_en     (do_write),
    .wr_addr   (table_address),
    .wr_data   (table_byte),
    .rd_en     (do_step),
    .rd_cluster(current_cluster),
    .entry     (entry)
  );

  // root directory sectors, rounded up
  fcw_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (do_start),
    .dividend({root_entries, 5'b0}),
    .divisor (bytes_per_sector),
    .done    (div_done),
    .result  (root_secs)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and handshake
  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (do_start) begin
          state_next = S_DIV;
        end else if (do_step) begin
          state_next = S_STEP;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_next = S_IDLE;
        end
      end
      S_STEP: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // products for the start and step paths, registered before their adds
  always_ff @(posedge clk) begin
    if (do_start) begin
      fat_area      <= 24'(sectors_per_fat) * 24'(fat_copies);
      reserved_hold <= reserved_sectors;
    end
    if (do_step) begin
      cluster_ofs <= 20'(current_cluster - FIRST_DATA_CLUSTER) * 20'(sectors_per_cluster);
    end
  end

  // chain state
  always_ff @(posedge clk) begin
    if (rst) begin
      current_cluster <= '0;
      chain_active    <= 1'b0;
      data_start_lba  <= '0;
    end else begin
      if (do_start) begin
        current_cluster <= start_cluster;
        chain_active    <= 1'b1;
      end
      if ((state == S_DIV) && div_done) begin
        data_start_lba <= LBA_W'(fat_area) + LBA_W'(reserved_hold) + LBA_W'(root_secs);
      end
      if (finish_step && chain_active) begin
        if (current_cluster < FIRST_DATA_CLUSTER || is_end) begin
          chain_active <= 1'b0;
        end else begin
          current_cluster <= entry;
        end
      end
    end
  end

  // output valid: set on a finished step, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish_step) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // output word
  always_ff @(posedge clk) begin
    if (finish_step) begin
      priority if (!chain_active) begin
        cluster      <= '0;
        sector_lba   <= '0;
        sector_count <= '0;
        next_cluster <= '0;
        end_of_chain <= 1'b1;
        status       <= ST_NO_CHAIN;
      end else if (current_cluster < FIRST_DATA_CLUSTER) begin
        cluster      <= current_cluster;
        sector_lba   <= '0;
        sector_count <= '0;
        next_cluster <= '0;
        end_of_chain <= 1'b1;
        status       <= ST_BAD;
      end else begin
        cluster      <= current_cluster;
        sector_lba   <= data_start_lba + LBA_W'(cluster_ofs);
        sector_count <= sectors_per_cluster;
        next_cluster <= entry;
        end_of_chain <= is_end;
        status       <= ST_OK;
      end
    end
  end

endmodule

`default_nettype wire

@@ design/fcw_ram.sv @@
// ----------------------------------------------------------------------------
// fcw_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fcw_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 8,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port, holds between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ design/fcw_fat.sv @@
// ----------------------------------------------------------------------------
// fcw_fat
// FAT byte store split into even and odd banks, so both bytes of a packed
// 12-bit entry come back in one read; unpacks the entry of a cluster.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fcw_fat import fcw_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 wr_en,
  input  wire logic [12:0]          wr_addr,
  input  wire logic [7:0]           wr_data,
  input  wire logic                 rd_en,
  input  wire logic [CLUSTER_W-1:0] rd_cluster,
  output logic      [CLUSTER_W-1:0] entry
);

  logic [IDX_W-1:0]   waddr_full;
  logic               wr_ok;
  logic [IDX_W-1:0]   idx_lo;
  logic [IDX_W-1:0]   idx_hi;
  logic [IDX_W-1:0]   even_full;
  logic [IDX_W-1:0]   odd_full;
  logic [BANK_AW-1:0] even_raddr;
  logic [BANK_AW-1:0] odd_raddr;
  logic [7:0]         even_q;
  logic [7:0]         odd_q;
  logic               swap;
  logic               odd_cluster;
  logic               lo_in;
  logic               hi_in;
  logic [7:0]         byte_lo;
  logic [7:0]         byte_hi;
  logic [15:0]        word;

  // drop writes beyond the store
  assign waddr_full = IDX_W'(wr_addr);
  assign wr_ok      = wr_en && (waddr_full < IDX_W'(TABLE_BYTES));

  // byte index of the entry: cluster * 3 / 2
  assign idx_lo     = IDX_W'(rd_cluster) + IDX_W'(rd_cluster[CLUSTER_W-1:1]);
  assign idx_hi     = idx_lo + IDX_W'(1);
  assign even_full  = idx_lo[0] ? idx_hi : idx_lo;
  assign odd_full   = idx_lo[0] ? idx_lo : idx_hi;
  assign even_raddr = even_full[ADDR_W-1:1];
  assign odd_raddr  = odd_full[ADDR_W-1:1];

  fcw_ram #(
    .DEPTH(BANK_DEPTH),
    .WIDTH(8)
  ) u_even (
    .clk  (clk),
    .we   (wr_ok && !waddr_full[0]),
    .waddr(waddr_full[ADDR_W-1:1]),
    .wdata(wr_data),
    .re   (rd_en),
    .raddr(even_raddr),
    .rdata(even_q)
  );

  fcw_ram #(
    .DEPTH(BANK_DEPTH),
    .WIDTH(8)
  ) u_odd (
    .clk  (clk),
    .we   (wr_ok && waddr_full[0]),
    .waddr(waddr_full[ADDR_W-1:1]),
    .wdata(wr_data),
    .re   (rd_en),
    .raddr(odd_raddr),
    .rdata(odd_q)
  );

  // hold byte order and range flags alongside the read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      swap        <= idx_lo[0];
      odd_cluster <= rd_cluster[0];
      lo_in       <= idx_lo < IDX_W'(TABLE_BYTES);
      hi_in       <= idx_hi < IDX_W'(TABLE_BYTES);
    end
  end

  // reassemble the word; bytes beyond the store read as zero
  assign byte_lo = lo_in ? (swap ? odd_q : even_q) : 8'd0;
  assign byte_hi = hi_in ? (swap ? even_q : odd_q) : 8'd0;
  assign word    = {byte_hi, byte_lo};
  assign entry   = odd_cluster ? word[15:4] : word[11:0];

endmodule

`default_nettype wire

@@ design/fcw_div.sv @@
// ----------------------------------------------------------------------------
// fcw_div
// Restoring divider, one quotient bit a cycle; returns the quotient rounded
// up, or zero for a zero divisor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fcw_div import fcw_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [DIVD_W-1:0] dividend,
  input  wire logic [DIVS_W-1:0] divisor,
  output logic                   done,
  output logic      [DIVD_W-1:0] result
);

  localparam int CNT_W = $clog2(DIVD_W + 1);

  logic              running;
  logic [CNT_W-1:0]  count;
  logic [DIVD_W-1:0] quo;
  logic [DIVS_W:0]   rem;
  logic [DIVS_W-1:0] dvs;
  logic              dvs_zero;
  logic [DIVS_W:0]   rem_sh;
  logic              ge;

  // shift in the next dividend bit and try the subtract
  assign rem_sh = {rem[DIVS_W-1:0], quo[DIVD_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      count   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        count   <= CNT_W'(DIVD_W);
      end else if (running) begin
        if (count == '0) begin
          running <= 1'b0;
          done    <= 1'b1;
        end else begin
          count <= count - CNT_W'(1);
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      quo      <= dividend;
      rem      <= '0;
      dvs      <= divisor;
      dvs_zero <= (divisor == '0);
    end else if (running) begin
      if (count == '0) begin
        result <= dvs_zero ? '0 : (quo + DIVD_W'(rem != '0));
      end else begin
        quo <= {quo[DIVD_W-2:0], ge};
        rem <= ge ? (rem_sh - {1'b0, dvs}) : rem_sh;
      end
    end
  end

endmodule

`default_nettype wire
